[rtl/gb5_pkg.sv]
// shared types and constants for the 5x5 gaussian blur rgb stream block
// no dependencies; imported by every module under rtl
package gb5_pkg;

	// field widths
	localparam int PIX_W   = 8;
	localparam int COORD_W = 13;
	localparam int DIM_W   = 14;

	// frame size limits
	localparam int MAX_WIDTH  = 8192;
	localparam int MAX_HEIGHT = 8192;
	localparam int MIN_DIM    = 5;

	// register reset values
	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(7680);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(4320);

	// line store geometry
	localparam int LINE_DEPTH = MAX_WIDTH;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int LINE_TAPS  = 4;

	// window geometry
	localparam int WIN      = 5;
	localparam int WIN_LAST = WIN - 1;
	localparam int WIN_HALF = WIN / 2;

	// kernel weights grouped by symmetry class, and the divide by 273
	localparam int SUM_W  = 17;
	localparam int PROD_W = 34;
	localparam logic [SUM_W-1:0] K_CORNER = SUM_W'(1);
	localparam logic [SUM_W-1:0] K_EDGE   = SUM_W'(4);
	localparam logic [SUM_W-1:0] K_AXIS   = SUM_W'(7);
	localparam logic [SUM_W-1:0] K_INNER  = SUM_W'(16);
	localparam logic [SUM_W-1:0] K_CROSS  = SUM_W'(26);
	localparam logic [SUM_W-1:0] K_CENTER = SUM_W'(41);
	// floor(x / 273) == (x * 122911) >> 25 for every x up to 123817,
	// which covers the largest weighted sum 255 * 273
	localparam logic [SUM_W-1:0] DIV_RECIP = SUM_W'(122911);
	localparam int DIV_SHIFT = 25;

	// output buffer
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// one window column, row 0 is the oldest line
	typedef rgb_t [WIN-1:0] column_t;
	// whole window, column 0 is the oldest column
	typedef column_t [WIN-1:0] window_t;
	// line store taps, tap 0 is the newest stored line
	typedef rgb_t [LINE_TAPS-1:0] taps_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               done;
	} meta_t;

	typedef struct packed {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               done;
	} result_t;

endpackage

[rtl/gb5_cell.sv]
// one window column cell: holds five vertical pixels, loads from its neighbor
// depends on gb5_pkg
module gb5_cell
	import gb5_pkg::*;
(
	input  logic    clk,
	input  logic    en,
	input  column_t d,
	output column_t q
);

	column_t col_q;

	// shift in the neighbor column on each accepted word
	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule

[rtl/gb5_line_buf.sv]
// line store: four previous lines per column address, registered read
// depends on gb5_pkg
module gb5_line_buf
	import gb5_pkg::*;
(
	input  logic               clk,
	input  logic               rd_en,
	input  logic [LINE_AW-1:0] rd_addr,
	output taps_t              rd_data,
	input  logic               wr_en,
	input  logic [LINE_AW-1:0] wr_addr,
	input  taps_t              wr_data
);

	taps_t mem [LINE_DEPTH];
	taps_t rd_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/gb5_kernel.sv]
// weighted 5x5 sum per channel and divide by 273, three pipeline stages
// depends on gb5_pkg
module gb5_kernel
	import gb5_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  window_t win,
	input  meta_t   in_meta,
	output logic    out_valid,
	output result_t out_res
);

	typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] plane_t;

	typedef struct packed {
		logic [9:0]       a;
		logic [10:0]      b;
		logic [9:0]       c;
		logic [9:0]       d;
		logic [9:0]       e;
		logic [PIX_W-1:0] f;
	} fold_t;

	// group pixels that share a weight, p[column][row]
	function automatic fold_t fold(input plane_t p);
		fold_t r;
		r.a = 10'(p[0][0]) + 10'(p[0][4]) + 10'(p[4][0]) + 10'(p[4][4]);
		r.b = 11'(p[0][1]) + 11'(p[0][3]) + 11'(p[4][1]) + 11'(p[4][3])
		    + 11'(p[1][0]) + 11'(p[1][4]) + 11'(p[3][0]) + 11'(p[3][4]);
		r.c = 10'(p[0][2]) + 10'(p[4][2]) + 10'(p[2][0]) + 10'(p[2][4]);
		r.d = 10'(p[1][1]) + 10'(p[1][3]) + 10'(p[3][1]) + 10'(p[3][3]);
		r.e = 10'(p[1][2]) + 10'(p[3][2]) + 10'(p[2][1]) + 10'(p[2][3]);
		r.f = p[2][2];
		return r;
	endfunction

	plane_t           plane [3];
	fold_t            fold_s3 [3];
	logic [SUM_W-1:0] sum_s4 [3];
	logic [PROD_W-1:0] prod_s5 [3];
	meta_t            meta_s3, meta_s4, meta_s5;
	logic             valid_s3, valid_s4, valid_s5;

	// split the window into channel planes
	always_comb begin
		for (int c = 0; c < WIN; c++) begin
			for (int r = 0; r < WIN; r++) begin
				plane[0][c][r] = win[c][r].red;
				plane[1][c][r] = win[c][r].green;
				plane[2][c][r] = win[c][r].blue;
			end
		end
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// fold, weight, multiply by reciprocal
	always_ff @(posedge clk) begin
		meta_s3 <= in_meta;
		meta_s4 <= meta_s3;
		meta_s5 <= meta_s4;
		for (int ch = 0; ch < 3; ch++) begin
			fold_s3[ch] <= fold(plane[ch]);
			sum_s4[ch]  <= SUM_W'(fold_s3[ch].a) * K_CORNER
			             + SUM_W'(fold_s3[ch].b) * K_EDGE
			             + SUM_W'(fold_s3[ch].c) * K_AXIS
			             + SUM_W'(fold_s3[ch].d) * K_INNER
			             + SUM_W'(fold_s3[ch].e) * K_CROSS
			             + SUM_W'(fold_s3[ch].f) * K_CENTER;
			prod_s5[ch] <= PROD_W'(sum_s4[ch]) * PROD_W'(DIV_RECIP);
		end
	end

	// quotient is the shifted product
	always_comb begin
		out_res.red    = prod_s5[0][DIV_SHIFT +: PIX_W];
		out_res.green  = prod_s5[1][DIV_SHIFT +: PIX_W];
		out_res.blue   = prod_s5[2][DIV_SHIFT +: PIX_W];
		out_res.column = meta_s5.column;
		out_res.row    = meta_s5.row;
		out_res.done   = meta_s5.done;
	end

	assign out_valid = valid_s5;

endmodule

[rtl/gaussian_blur_5x5_rgb_stream.sv]
// top level of the 5x5 gaussian blur rgb stream block
// depends on gb5_pkg, gb5_line_buf, gb5_cell, gb5_kernel
//
// usage:
// - input words arrive in raster order on s_axis; tuser marks the first pixel
//   of a frame and restarts the row and column counters.
// - output words on m_axis carry the blurred pixel and its centre position;
//   only pixels at least two away from every edge produce a word, and tlast
//   is set on the last such pixel of a frame.
// - frame_width and frame_height are written through the cfg port while the
//   block is idle; values outside 5..8192 are clamped when written.
// - throughput is one pixel per cycle while s_axis_tready is high; an accepted
//   pixel passes line store read, window shift, fold, weighted sum, reciprocal
//   multiply and output buffer registers before output valid.
// - a 16-word output buffer decouples the two sides; s_axis_tready stays high
//   until results pending in the pipe and buffer reach 16, so a stalled
//   receiver only stops input once that buffer is committed.
// - reset clears counters, pipe valids and the buffer and loads the default
//   frame size 7680 x 4320; line store and window contents are not cleared
//   and the first four lines of a frame never produce output.
module gaussian_blur_5x5_rgb_stream
	import gb5_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	// input pixel stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [23:0]      s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
	input  logic             s_axis_tuser,  // frame_start
	// output result stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // out_red, out_green, out_blue,
	                                        // out_column, out_row, zero pad
	output logic             m_axis_tlast   // frame_done
);

	logic [DIM_W-1:0]   eff_w_q, eff_h_q, cfg_clamped;
	logic [COORD_W-1:0] col_cnt_q, row_cnt_q;
	logic               s_acc, m_acc;

	// s0 position logic
	logic [DIM_W-1:0]   c0, r0, c1, r1, cn, rn;
	logic [COORD_W-1:0] col0, row0, col_nx, row_nx;
	logic               emit0, done0;
	rgb_t               pix0;

	// s1 registers
	rgb_t               pix_s1;
	logic [COORD_W-1:0] col_s1, row_s1;
	logic               done_s1, emit_s1, valid_s1, fwd_s1;
	taps_t              fwd_data_s1, rd_data, taps_s1, wr_data;
	column_t            column_s1;

	// s2 registers and window
	meta_t              meta_s2;
	logic               emit_s2;
	window_t            win;
	column_t            cell_in [WIN];

	// kernel output and output buffer
	logic               k_valid;
	result_t            k_res;
	result_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q, pend_q;
	result_t            head;

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (pend_q != (FIFO_AW+1)'(FIFO_DEPTH));

	// clamp a written frame dimension to the supported range
	always_comb begin
		if (cfg_data < DIM_W'(MIN_DIM)) begin
			cfg_clamped = DIM_W'(MIN_DIM);
		end else if (cfg_data > DIM_W'(MAX_WIDTH)) begin
			cfg_clamped = DIM_W'(MAX_WIDTH);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WIDTH_RESET;
			eff_h_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					eff_w_q <= cfg_clamped;
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data > DIM_W'(MAX_HEIGHT)) begin
						eff_h_q <= DIM_W'(MAX_HEIGHT);
					end else begin
						eff_h_q <= cfg_clamped;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// position of the incoming word and of the next one
	always_comb begin
		pix0.red   = s_axis_tdata[7:0];
		pix0.green = s_axis_tdata[15:8];
		pix0.blue  = s_axis_tdata[23:16];
		c0 = s_axis_tuser ? '0 : {1'b0, col_cnt_q};
		r0 = s_axis_tuser ? '0 : {1'b0, row_cnt_q};
		c1 = c0;
		r1 = r0;
		if (c0 >= eff_w_q) begin
			c1 = '0;
			r1 = r0 + DIM_W'(1);
		end
		if (r1 >= eff_h_q) begin
			r1 = '0;
		end
		col0 = c1[COORD_W-1:0];
		row0 = r1[COORD_W-1:0];
		cn = {1'b0, col0} + DIM_W'(1);
		rn = {1'b0, row0} + DIM_W'(1);
		col_nx = cn[COORD_W-1:0];
		row_nx = row0;
		if (cn >= eff_w_q) begin
			col_nx = '0;
			row_nx = (rn >= eff_h_q) ? '0 : rn[COORD_W-1:0];
		end
		done0 = (cn == eff_w_q) && (rn == eff_h_q);
		emit0 = (col0 >= COORD_W'(WIN_LAST)) && (row0 >= COORD_W'(WIN_LAST));
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (s_acc) begin
			col_cnt_q <= col_nx;
			row_cnt_q <= row_nx;
		end
	end

	// s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= s_acc;
			emit_s1  <= s_acc && emit0;
			fwd_s1   <= s_acc && valid_s1 && (col_s1 == col0);
		end
	end

	// s1 payload; forward the line write when the same column is read next
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_s1  <= pix0;
			col_s1  <= col0;
			row_s1  <= row0;
			done_s1 <= done0;
		end
		fwd_data_s1 <= wr_data;
	end

	gb5_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (s_acc),
		.rd_addr (col0),
		.rd_data (rd_data),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	// line taps shift down by one line, new pixel becomes the newest line
	always_comb begin
		taps_s1 = fwd_s1 ? fwd_data_s1 : rd_data;
		wr_data = {taps_s1[LINE_TAPS-2:0], pix_s1};
		for (int k = 0; k < LINE_TAPS; k++) begin
			column_s1[LINE_TAPS-1-k] = taps_s1[k];
		end
		column_s1[WIN_LAST] = pix_s1;
	end

	// window: chain of column cells, newest column enters at the end
	always_comb begin
		for (int k = 0; k < WIN_LAST; k++) begin
			cell_in[k] = win[k+1];
		end
		cell_in[WIN_LAST] = column_s1;
	end

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		gb5_cell u_cell (
			.clk (clk),
			.en  (valid_s1),
			.d   (cell_in[k]),
			.q   (win[k])
		);
	end

	// s2 position of the window centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2.column <= col_s1 - COORD_W'(WIN_HALF);
		meta_s2.row    <= row_s1 - COORD_W'(WIN_HALF);
		meta_s2.done   <= done_s1;
	end

	gb5_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (emit_s2),
		.win       (win),
		.in_meta   (meta_s2),
		.out_valid (k_valid),
		.out_res   (k_res)
	);

	// results committed to the pipe or sitting in the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (FIFO_AW+1)'(s_acc && emit0) - (FIFO_AW+1)'(m_acc);
		end
	end

	// output buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (k_valid) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (m_acc) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(k_valid) - (FIFO_AW+1)'(m_acc);
		end
	end

	// output buffer storage
	always_ff @(posedge clk) begin
		if (k_valid) begin
			fifo_q[wr_ptr_q] <= k_res;
		end
	end

	// output word
	always_comb begin
		head          = fifo_q[rd_ptr_q];
		m_axis_tvalid = (cnt_q != '0);
		m_axis_tdata  = {6'b0, head.row, head.column, head.blue, head.green, head.red};
		m_axis_tlast  = head.done;
	end

endmodule
